// ===== hw/rtl/assert_macros.svh =====
// Concurrent assertion helpers used by the dref_checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("%m: assertion failed");

`endif

// ===== hw/rtl/dref_pkg.sv =====
`timescale 1ns / 1ps
package dref_pkg;

    localparam int DIGITS    = 6;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 5;
    localparam int STEP_W    = 4;

    localparam logic [IDX_W-1:0] SUM_FIRST_IDX = 5'd3;
    localparam logic [IDX_W-1:0] AXIS_IDX      = 5'd22;
    localparam logic [IDX_W-1:0] DIGIT_IDX     = 5'd24;
    localparam logic [IDX_W-1:0] LAST_IDX      = 5'd30;
    localparam logic [STEP_W-1:0] LAST_STEP    = 4'd15;

    localparam logic [7:0] START_BYTE   = 8'h7E;
    localparam logic [7:0] LEN_LO_BYTE  = 8'h1B;
    localparam logic [7:0] TX_REQ_TYPE  = 8'h10;
    localparam logic [7:0] FRAME_ID     = 8'h01;
    localparam logic [7:0] LETTER_X     = 8'h78;
    localparam logic [7:0] LETTER_Y     = 8'h79;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ALL_ONES     = 8'hFF;

    typedef struct packed {
        logic             axis;
        logic [BCD_W-1:0] bcd;
    } dref_entry_t;

    typedef struct packed {
        logic        valid;
        dref_entry_t entry;
    } dref_push_t;

    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = START_BYTE;
            5'd1:    b = 8'h00;
            5'd2:    b = LEN_LO_BYTE;
            5'd3:    b = TX_REQ_TYPE;
            5'd4:    b = FRAME_ID;
            5'd5:    b = 8'h00;
            5'd6:    b = 8'h13;
            5'd7:    b = 8'hA2;
            5'd8:    b = 8'h00;
            5'd9:    b = 8'h40;
            5'd10:   b = 8'hB0;
            5'd11:   b = 8'h98;
            5'd12:   b = 8'h96;
            5'd13:   b = ALL_ONES;
            5'd14:   b = 8'hFE;
            5'd15:   b = 8'h00;
            5'd16:   b = 8'h00;
            5'd17:   b = 8'h76;
            5'd18:   b = 8'h61;
            5'd19:   b = 8'h6C;
            5'd20:   b = 8'h6F;
            5'd21:   b = 8'h72;
            5'd23:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/dref_front.sv =====
`timescale 1ns / 1ps
module dref_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_axis,
    input  logic [31:0]                 in_value,
    input  logic                        q_full,
    output dref_pkg::dref_push_t        push
);
    import dref_pkg::*;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic               axis_reg, axis_next;

    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                 input logic bit_in);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int k = 0; k < DIGITS; k++) begin
            if (bcd[4*k +: 4] >= 4'd5)
            begin
                adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bit_in};
    endfunction

    assign in_ready = !busy_reg;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        step_next  = step_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        axis_next  = axis_reg;
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next  = 1'b1;
                done_next  = 1'b0;
                step_next  = '0;
                shift_next = in_value;
                bcd_next   = '0;
                axis_next  = in_axis;
            end
        end
        else if (!done_reg)
        begin
            // two bits per cycle, top digits beyond six are dropped
            bcd_next   = dabble(dabble(bcd_reg, shift_reg[VALUE_W-1]), shift_reg[VALUE_W-2]);
            shift_next = {shift_reg[VALUE_W-3:0], 2'b00};
            step_next  = step_reg + 4'd1;
            done_next  = (step_reg == LAST_STEP);
        end
        else if (!q_full)
        begin
            busy_next = 1'b0;
            done_next = 1'b0;
        end
    end

    assign push.valid      = busy_reg && done_reg && !q_full;
    assign push.entry.axis = axis_reg;
    assign push.entry.bcd  = bcd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
        axis_reg  <= axis_next;
    end

endmodule

// ===== hw/rtl/dref_fifo.sv =====
`timescale 1ns / 1ps
module dref_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dref_pkg::dref_push_t  push,
    output logic                  full,
    output logic                  head_valid,
    output dref_pkg::dref_entry_t head,
    input  logic                  pop
);
    import dref_pkg::*;

    dref_entry_t mem_reg [0:1];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push.valid ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== hw/rtl/dref_back.sv =====
`timescale 1ns / 1ps
module dref_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  dref_pkg::dref_entry_t head,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last
);
    import dref_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sum_reg, sum_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             advance;
    logic [7:0]       cur_byte;
    logic [3:0]       nibble;

    assign advance = head_valid && (!valid_reg || out_ready);
    assign pop     = advance && (idx_reg == LAST_IDX);

    always_comb
    begin
        case (idx_reg)
            5'd24:   nibble = head.bcd[23:20];
            5'd25:   nibble = head.bcd[19:16];
            5'd26:   nibble = head.bcd[15:12];
            5'd27:   nibble = head.bcd[11:8];
            5'd28:   nibble = head.bcd[7:4];
            default: nibble = head.bcd[3:0];
        endcase
        if (idx_reg == LAST_IDX)
        begin
            cur_byte = ALL_ONES - sum_reg;
        end
        else if (idx_reg >= DIGIT_IDX)
        begin
            cur_byte = ASCII_ZERO | {4'h0, nibble};
        end
        else if (idx_reg == AXIS_IDX)
        begin
            cur_byte = head.axis ? LETTER_Y : LETTER_X;
        end
        else
        begin
            cur_byte = hdr_byte(idx_reg);
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            idx_next   = (idx_reg == LAST_IDX) ? '0 : idx_reg + 5'd1;
            if (idx_reg < SUM_FIRST_IDX)
            begin
                sum_next = '0;
            end
            else if (idx_reg != LAST_IDX)
            begin
                sum_next = sum_reg + cur_byte;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (advance)
        begin
            byte_reg <= cur_byte;
            last_reg <= (idx_reg == LAST_IDX);
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

// ===== hw/rtl/distance_report_frame_encoder_core.sv =====
`timescale 1ns / 1ps
// A beat passes 16 two-bit BCD conversion steps, the queue push and the
// output register before its first frame byte appears.
// The byte serializer sends each 31-byte frame and stalls on m_axis_tready.
// The converter runs ahead on the next item through a two-entry queue.
// Reset (rst_n low, asynchronous) empties the queue and output register.
module distance_report_frame_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic [0:0]  s_axis_tuser,  // [0] axis
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] frame_byte
    output logic        m_axis_tlast
);
    import dref_pkg::*;

    dref_push_t  push;
    dref_entry_t head;
    logic        q_full;
    logic        head_valid;
    logic        pop;

    dref_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_axis  (s_axis_tuser[0]),
        .in_value (s_axis_tdata),
        .q_full   (q_full),
        .push     (push)
    );

    dref_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    dref_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

// ===== hw/rtl/dref_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dref_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);
    import dref_pkg::*;

    logic [IDX_W-1:0] beat_cnt_reg, beat_cnt_next;
    logic             m_beat;
    logic             m_stall;
    logic             s_beat;

    assign m_beat  = m_axis_tvalid && m_axis_tready;
    assign m_stall = m_axis_tvalid && !m_axis_tready;
    assign s_beat  = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        beat_cnt_next = beat_cnt_reg;
        if (m_beat)
        begin
            beat_cnt_next = (beat_cnt_reg == LAST_IDX) ? '0 : beat_cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_cnt_reg <= '0;
        end
        else
        begin
            beat_cnt_reg <= beat_cnt_next;
        end
    end

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_stall, m_axis_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_stall, $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `ASSERT_IMPL(a_last_place, clk, rst_n, m_beat, m_axis_tlast == (beat_cnt_reg == LAST_IDX))
    `ASSERT_IMPL(a_frame_start, clk, rst_n, m_beat && (beat_cnt_reg == '0), m_axis_tdata == START_BYTE)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_beat, !s_axis_tready)

endmodule

bind distance_report_frame_encoder_core dref_checker u_dref_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import dref_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    localparam int FRAME_BYTES = 31;
    localparam int HEADER_BYTES = 24;
    localparam int LETTER_POS = 22;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [HEADER_BYTES*8-1:0] REPORT_HEADER = {
        8'h7E, 8'h00, 8'h1B, 8'h10, 8'h01,
        8'h00, 8'h13, 8'hA2, 8'h00, 8'h40, 8'hB0, 8'h98, 8'h96,
        8'hFF, 8'hFE, 8'h00, 8'h00,
        8'h76, 8'h61, 8'h6C, 8'h6F, 8'h72, 8'h78, 8'h20
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    frame_beat_t frame_beats_q[$];
    int          err_count;
    int          src_idle_pct;
    int          sink_stall_pct;

    distance_report_frame_encoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            if (err_count < 40)
                $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
            err_count++;
        end
    endtask

    function automatic void queue_report_frame(input logic axis, input logic [31:0] value);
        logic [7:0]  frame [FRAME_BYTES];
        logic [7:0]  sum;
        logic [31:0] rest;
        logic [31:0] weight;
        logic [31:0] digit;
        frame_beat_t beat;
        begin
            for (int i = 0; i < HEADER_BYTES; i++)
                frame[i] = REPORT_HEADER[8*(HEADER_BYTES-1-i) +: 8];
            frame[LETTER_POS] = axis ? LETTER_Y : LETTER_X;
            rest = value % 32'd1000000;
            weight = 32'd100000;
            for (int i = HEADER_BYTES; i < FRAME_BYTES - 1; i++)
            begin
                digit = rest / weight;
                rest = rest - digit * weight;
                frame[i] = ASCII_ZERO + digit[7:0];
                weight = weight / 32'd10;
            end
            sum = 8'h00;
            for (int i = 3; i < FRAME_BYTES - 1; i++)
                sum = sum + frame[i];
            frame[FRAME_BYTES-1] = ALL_ONES - sum;
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                beat.data = frame[i];
                beat.last = (i == FRAME_BYTES - 1);
                frame_beats_q.push_back(beat);
            end
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_report(input logic axis, input logic [31:0] value);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= $urandom;
                s_axis_tuser  <= 1'($urandom_range(1));
                @(negedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= value;
            s_axis_tuser  <= axis;
            do
                @(posedge clk);
            while (!s_axis_tready);
            queue_report_frame(axis, value);
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        begin
            s_axis_tvalid <= 1'b0;
            while (frame_beats_q.size() != 0)
                @(negedge clk);
            repeat (DRAIN_CYCLES) @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        frame_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_beats_q.size() == 0)
            begin
                report_mismatch("unexpected beat", {24'h0, m_axis_tdata}, 32'h0);
            end
            else
            begin
                want = frame_beats_q.pop_front();
                if (m_axis_tdata !== want.data)
                    report_mismatch("tdata", {24'h0, m_axis_tdata}, {24'h0, want.data});
                if (m_axis_tlast !== want.last)
                    report_mismatch("tlast", {31'h0, m_axis_tlast}, {31'h0, want.last});
            end
        end
    end

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        begin
            case ($urandom_range(3))
                0:       v = $urandom_range(999999);
                1:       v = $urandom_range(4293) * 32'd1000000
                             + ($urandom_range(1) ? 32'd999999 : 32'd0);
                default: v = $urandom;
            endcase
            return v;
        end
    endfunction

    task automatic run_random_reports(input int count, input int src_pct, input int sink_pct);
        begin
            src_idle_pct = src_pct;
            sink_stall_pct = sink_pct;
            for (int i = 0; i < count; i++)
                send_report(1'($urandom_range(1)), random_value());
            wait_drained();
        end
    endtask

    task automatic test_digit_range();
        begin
            src_idle_pct = 0;
            sink_stall_pct = 0;
            send_report(1'b0, 32'd0);
            send_report(1'b1, 32'd0);
            send_report(1'b0, 32'd999999);
            send_report(1'b1, 32'd999999);
            send_report(1'b0, 32'd1);
            send_report(1'b1, 32'd123456);
            send_report(1'b0, 32'd654321);
            send_report(1'b1, 32'd100000);
            send_report(1'b0, 32'd98765);
            send_report(1'b1, 32'd500005);
            send_report(1'b0, 32'd10);
            wait_drained();
        end
    endtask

    task automatic test_wraparound();
        begin
            send_report(1'b0, 32'd1000000);
            send_report(1'b1, 32'd1000001);
            send_report(1'b0, 32'd1999999);
            send_report(1'b1, 32'hFFFFFFFF);
            send_report(1'b0, 32'hFFFFFFFF);
            send_report(1'b1, 32'h80000000);
            send_report(1'b0, 32'd4294000000);
            send_report(1'b1, 32'h55555555);
            send_report(1'b0, 32'hAAAAAAAA);
            send_report(1'b1, 32'd12345678);
            wait_drained();
        end
    endtask

    task automatic test_streaming_no_idle();
        run_random_reports(50, 0, 0);
    endtask

    task automatic test_sender_gaps();
        run_random_reports(50, 72, 0);
    endtask

    task automatic test_receiver_stalls();
        run_random_reports(50, 0, 72);
    endtask

    task automatic test_mixed_idle();
        run_random_reports(60, 17, 17);
    endtask

    initial
    begin
        err_count = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 32'h0;
        s_axis_tuser = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_digit_range();
        test_wraparound();
        test_streaming_no_idle();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idle();
        if (frame_beats_q.size() != 0)
            report_mismatch("beats left over", frame_beats_q.size(), 32'h0);
        if (err_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb NOT OK");
        $finish;
    end
endmodule
